// ----- design/assert_macros.svh -----
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent-assertion shorthands, clocked on clk, quiet in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, sampled on clk, disabled while rst_n is low.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Invariant that holds at every sampled edge.
`define ASSERT_INV(label, expr, msg) \
    `ASSERT_PROP(label, (expr), msg)

`endif

// ----- design/mmapc_pkg.sv -----
// -----------------------------------------------------------------------------
// mmapc_pkg
// Widths, codes and types of the masked moving-average pump control unit.
// -----------------------------------------------------------------------------
package mmapc_pkg;

    localparam int WINDOW   = 50;
    localparam int SAMPLE_W = 12;
    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    // sum of up to WINDOW 12-bit signed samples
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int MAG_W    = SUM_W - 1;
    localparam int STEP_W   = $clog2(MAG_W);

    localparam logic signed [SAMPLE_W-1:0] THRESH_RESET = 12'sd416;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_HEAT   = 2'd1,
        ACT_PUMP   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_DIV    = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

endpackage

// ----- design/mmapc_if.sv -----
// -----------------------------------------------------------------------------
// mmapc_if
// Valid/ready channels: command beats in, status beats out.
// -----------------------------------------------------------------------------
interface mmapc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            action;
    logic signed [mmapc_pkg::SAMPLE_W-1:0] sample;
    logic                                  sample_valid;
    logic                                  level;

    modport source (output valid, action, sample, sample_valid, level, input ready);
    modport sink   (input valid, action, sample, sample_valid, level, output ready);
endinterface

interface mmapc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mmapc_pkg::SAMPLE_W-1:0] average;
    logic                                  average_valid;
    logic                                  heat_on;
    logic                                  pump_on;
    logic                                  pump_auto_off;
    logic                                  relay_changed;

    modport source (output valid, average, average_valid, heat_on, pump_on,
                    pump_auto_off, relay_changed, input ready);
    modport sink   (input valid, average, average_valid, heat_on, pump_on,
                    pump_auto_off, relay_changed, output ready);
endinterface

// ----- design/masked_moving_average_pump_control_unit.sv -----
// -----------------------------------------------------------------------------
// masked_moving_average_pump_control_unit
// Moving average over a 50-slot ring of masked samples, with pump cut-off.
// -----------------------------------------------------------------------------
// A sample beat runs through update of the ring, running sum and valid count,
// then the serial restoring divider (one quotient bit per cycle, one per bit
// of the sum magnitude), then finish, which applies the sign, runs the pump
// check and registers the status beat, and then returns to idle. A sample
// that leaves no valid entries skips the divider, and the other beats go from
// idle straight to finish. Input ready is low while a beat is in work. The
// status beat sits in an output register, so the next command is taken while
// it waits; the block only stalls when a new status is ready and the previous
// one is unread.
// -----------------------------------------------------------------------------
module masked_moving_average_pump_control_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic signed [mmapc_pkg::SAMPLE_W-1:0] cfg_wr_data,
    mmapc_in_if.sink                              in_ch,
    mmapc_out_if.source                           out_ch
);

    localparam int WINDOW   = mmapc_pkg::WINDOW;
    localparam int SAMPLE_W = mmapc_pkg::SAMPLE_W;
    localparam int SLOT_W   = mmapc_pkg::SLOT_W;
    localparam int CNT_W    = mmapc_pkg::CNT_W;
    localparam int SUM_W    = mmapc_pkg::SUM_W;
    localparam int MAG_W    = mmapc_pkg::MAG_W;
    localparam int STEP_W   = mmapc_pkg::STEP_W;

    mmapc_pkg::state_t             state_reg, state_next;
    logic signed [SAMPLE_W-1:0]    thresh_reg;

    mmapc_pkg::action_t            act_reg;
    logic signed [SAMPLE_W-1:0]    smp_reg;
    logic                          svld_reg;
    logic                          lvl_reg;

    logic signed [SAMPLE_W-1:0]    ring_mem [WINDOW];
    logic signed [SAMPLE_W-1:0]    rd_reg;
    logic [WINDOW-1:0]             ring_vld_reg;
    logic [SLOT_W-1:0]             slot_reg;
    logic                          ring_we;

    logic signed [SUM_W-1:0]       sum_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic signed [SAMPLE_W-1:0]    avg_reg;
    logic                          known_reg;
    logic                          heat_reg;
    logic                          pump_reg;

    logic [MAG_W-1:0]              dvd_reg;
    logic [CNT_W-1:0]              rem_reg;
    logic                          neg_reg;
    logic [STEP_W-1:0]             step_reg;
    logic                          avg_upd_reg;

    logic                          out_vld_reg;
    logic signed [SAMPLE_W-1:0]    out_avg_reg;
    logic                          out_known_reg;
    logic                          out_heat_reg;
    logic                          out_pump_reg;
    logic                          out_auto_reg;
    logic                          out_chg_reg;

    logic                          in_accept;
    logic                          out_load;
    logic                          old_vld;
    logic signed [SUM_W-1:0]       old_term;
    logic signed [SUM_W-1:0]       new_term;
    logic signed [SUM_W-1:0]       sum_upd;
    logic signed [SUM_W-1:0]       sum_neg;
    logic [CNT_W-1:0]              cnt_upd;
    logic [MAG_W-1:0]              mag_upd;
    logic [SLOT_W-1:0]             slot_inc;
    logic [CNT_W:0]                rem_sh;
    logic [CNT_W:0]                rem_sub;
    logic                          rem_fits;
    logic [SAMPLE_W-1:0]           quo;
    logic signed [SAMPLE_W-1:0]    avg_div;
    logic signed [SAMPLE_W-1:0]    fin_avg;
    logic                          fin_known;
    logic                          fin_heat;
    logic                          fin_pump;
    logic                          fin_auto;
    logic                          fin_chg;

    assign in_accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == mmapc_pkg::S_IDLE);
    assign out_load = (state_reg == mmapc_pkg::S_FINISH) && (!out_vld_reg || out_ch.ready);
    assign ring_we = (state_reg == mmapc_pkg::S_UPDATE);

    // ring update terms; rd_reg holds the slot read at acceptance
    assign old_vld  = ring_vld_reg[slot_reg];
    assign old_term = old_vld ? SUM_W'(rd_reg) : '0;
    assign new_term = svld_reg ? SUM_W'(smp_reg) : '0;
    assign sum_upd  = sum_reg - old_term + new_term;
    assign cnt_upd  = cnt_reg - CNT_W'(old_vld) + CNT_W'(svld_reg);
    assign sum_neg  = -sum_upd;
    assign mag_upd  = sum_upd[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_upd[MAG_W-1:0];
    assign slot_inc = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;

    // restoring divider step: magnitude of sum by valid count
    assign rem_sh   = {rem_reg, dvd_reg[MAG_W-1]};
    assign rem_fits = (rem_sh >= {1'b0, cnt_reg});
    assign rem_sub  = rem_sh - {1'b0, cnt_reg};

    // truncation toward zero: divide magnitudes, then restore sign
    assign quo     = dvd_reg[SAMPLE_W-1:0];
    assign avg_div = neg_reg ? -$signed(quo) : $signed(quo);

    always_comb
    begin
        fin_avg   = avg_upd_reg ? avg_div : avg_reg;
        fin_known = known_reg || avg_upd_reg;
        fin_heat  = heat_reg;
        fin_pump  = pump_reg;
        fin_auto  = 1'b0;
        fin_chg   = 1'b0;
        unique case (act_reg)
            mmapc_pkg::ACT_SAMPLE:
            begin
                if (fin_known && !heat_reg && pump_reg && (fin_avg < thresh_reg))
                begin
                    fin_pump = 1'b0;
                    fin_auto = 1'b1;
                end
            end
            mmapc_pkg::ACT_HEAT:
            begin
                fin_chg  = (lvl_reg != heat_reg);
                fin_heat = lvl_reg;
            end
            mmapc_pkg::ACT_PUMP:
            begin
                fin_chg  = (lvl_reg != pump_reg);
                fin_pump = lvl_reg;
            end
            default:
            begin
                fin_chg = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmapc_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    if (mmapc_pkg::action_t'(in_ch.action) == mmapc_pkg::ACT_SAMPLE)
                        state_next = mmapc_pkg::S_UPDATE;
                    else
                        state_next = mmapc_pkg::S_FINISH;
                end
            end
            mmapc_pkg::S_UPDATE:
            begin
                state_next = (cnt_upd != '0) ? mmapc_pkg::S_DIV : mmapc_pkg::S_FINISH;
            end
            mmapc_pkg::S_DIV:
            begin
                if (step_reg == '0)
                    state_next = mmapc_pkg::S_FINISH;
            end
            mmapc_pkg::S_FINISH:
            begin
                if (out_load)
                    state_next = mmapc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mmapc_pkg::S_IDLE;
            end
        endcase
    end

    // ring storage
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[slot_reg] <= smp_reg;
        rd_reg <= ring_mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mmapc_pkg::S_IDLE;
            thresh_reg   <= mmapc_pkg::THRESH_RESET;
            ring_vld_reg <= '0;
            slot_reg     <= '0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            avg_reg      <= '0;
            known_reg    <= 1'b0;
            heat_reg     <= 1'b0;
            pump_reg     <= 1'b0;
            avg_upd_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                thresh_reg <= cfg_wr_data;
            if (in_accept)
                avg_upd_reg <= 1'b0;
            if (ring_we)
            begin
                ring_vld_reg[slot_reg] <= svld_reg;
                slot_reg    <= slot_inc;
                sum_reg     <= sum_upd;
                cnt_reg     <= cnt_upd;
                avg_upd_reg <= (cnt_upd != '0);
            end
            if (out_load)
            begin
                avg_reg     <= fin_avg;
                known_reg   <= fin_known;
                heat_reg    <= fin_heat;
                pump_reg    <= fin_pump;
                out_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // command capture, divider datapath and status payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg  <= mmapc_pkg::action_t'(in_ch.action);
            smp_reg  <= in_ch.sample;
            svld_reg <= in_ch.sample_valid;
            lvl_reg  <= in_ch.level;
        end
        if (ring_we)
        begin
            dvd_reg  <= mag_upd;
            neg_reg  <= sum_upd[SUM_W-1];
            rem_reg  <= '0;
            step_reg <= STEP_W'(MAG_W - 1);
        end
        else if (state_reg == mmapc_pkg::S_DIV)
        begin
            dvd_reg  <= {dvd_reg[MAG_W-2:0], rem_fits};
            rem_reg  <= rem_fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            step_reg <= step_reg - 1'b1;
        end
        if (out_load)
        begin
            out_avg_reg   <= fin_avg;
            out_known_reg <= fin_known;
            out_heat_reg  <= fin_heat;
            out_pump_reg  <= fin_pump;
            out_auto_reg  <= fin_auto;
            out_chg_reg   <= fin_chg;
        end
    end

    assign out_ch.valid         = out_vld_reg;
    assign out_ch.average       = out_avg_reg;
    assign out_ch.average_valid = out_known_reg;
    assign out_ch.heat_on       = out_heat_reg;
    assign out_ch.pump_on       = out_pump_reg;
    assign out_ch.pump_auto_off = out_auto_reg;
    assign out_ch.relay_changed = out_chg_reg;

`include "assert_macros.svh"

    `ASSERT_INV(a_cnt_matches_mask, $countones(ring_vld_reg) == int'(cnt_reg), "valid count out of step with ring mask")
    `ASSERT_PROP(a_empty_sum_zero, (cnt_reg == '0) |-> (sum_reg == '0), "running sum nonzero with no valid entries")
    `ASSERT_PROP(a_out_from_finish, $rose(out_vld_reg) |-> $past(state_reg == mmapc_pkg::S_FINISH), "status beat raised outside finish")
    `ASSERT_PROP(a_auto_off_state, (out_vld_reg && out_auto_reg) |-> (!out_pump_reg && !out_heat_reg && out_known_reg), "pump cut-off reported with inconsistent relays")

endmodule

// ----- tb/tb_masked_moving_average_pump_control_unit.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_masked_moving_average_pump_control_unit
// Self-checking bench for the moving-average pump control unit.
// A short table of hand-picked commands runs first, then six random segments
// with changing cut-off thresholds and changing idle patterns on both channels.
// Every status beat is compared field by field, for the first table rows with
// set values, else with an in-bench model of sample ring, sum, average, relays.
// -----------------------------------------------------------------------------
module tb_masked_moving_average_pump_control_unit;

    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SEG_ITEMS     = 135;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        mmapc_pkg::action_t act;
        logic [11:0]        sample;
        logic               svalid;
        logic               level;
    } cmd_t;

    typedef struct packed {
        logic [11:0] avg;
        logic        avg_ok;
        logic        heat;
        logic        pump;
        logic        auto_off;
        logic        changed;
    } status_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic signed [mmapc_pkg::SAMPLE_W-1:0] cfg_wr_data;

    mmapc_in_if  in_ch ();
    mmapc_out_if out_ch ();

    masked_moving_average_pump_control_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // model state
    bit  ring_ok [mmapc_pkg::WINDOW];
    int  ring_val [mmapc_pkg::WINDOW];
    int  wr_slot;
    int  run_sum;
    int  run_cnt;
    int  avg_hold;
    bit  avg_seen;
    bit  heat_st;
    bit  pump_st;
    int  cut_thresh;

    status_t pending_status [$];

    // directed table
    cmd_t    dir_cmd [$];
    bit      dir_known [$];
    status_t dir_status [$];

    int  mismatches;
    int  cycle_count;
    int  snd_idle;
    int  rcv_idle;
    bit  stall_req;
    int  hold_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** masked_moving_average_pump_control_unit: FAILED **");
            $finish;
        end
    end

    function automatic status_t predict_status(cmd_t c);
        status_t r;
        int      s;
        s = int'($signed(c.sample));
        r.auto_off = 1'b0;
        r.changed  = 1'b0;
        unique case (c.act)
            mmapc_pkg::ACT_SAMPLE:
            begin
                if (ring_ok[wr_slot])
                begin
                    run_sum -= ring_val[wr_slot];
                    run_cnt--;
                end
                ring_ok[wr_slot]  = c.svalid;
                ring_val[wr_slot] = c.svalid ? s : 0;
                if (c.svalid)
                begin
                    run_sum += s;
                    run_cnt++;
                end
                wr_slot = (wr_slot == mmapc_pkg::WINDOW - 1) ? 0 : wr_slot + 1;
                // SV division truncates toward zero, as the divider does
                if (run_cnt > 0)
                begin
                    avg_hold = run_sum / run_cnt;
                    avg_seen = 1'b1;
                end
                if (avg_seen && !heat_st && pump_st && avg_hold < cut_thresh)
                begin
                    pump_st    = 1'b0;
                    r.auto_off = 1'b1;
                end
            end
            mmapc_pkg::ACT_HEAT:
            begin
                r.changed = (c.level != heat_st);
                heat_st   = c.level;
            end
            mmapc_pkg::ACT_PUMP:
            begin
                r.changed = (c.level != pump_st);
                pump_st   = c.level;
            end
            default: ;
        endcase
        r.avg    = avg_hold[11:0];
        r.avg_ok = avg_seen;
        r.heat   = heat_st;
        r.pump   = pump_st;
        return r;
    endfunction

    task automatic flag_field(string name, int got, int want);
        if (got != want)
        begin
            if (mismatches < 40)
                $display("mismatch at cycle %0d: %s got %0d expected %0d",
                         cycle_count, name, got, want);
            mismatches++;
        end
    endtask

    // waits out the sender idle gap, then holds the beat until accepted
    task automatic drive_cmd(cmd_t c);
        while ($urandom_range(99) < snd_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= c.act;
        in_ch.sample       <= c.sample;
        in_ch.sample_valid <= c.svalid;
        in_ch.level        <= c.level;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic issue(cmd_t c);
        drive_cmd(c);
        pending_status.push_back(predict_status(c));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_thresh(int v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[11:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cut_thresh = v;
    endtask

    task automatic add_row(mmapc_pkg::action_t a, int s, bit sv, bit lv);
        cmd_t c;
        c.act    = a;
        c.sample = s[11:0];
        c.svalid = sv;
        c.level  = lv;
        dir_cmd.push_back(c);
        dir_known.push_back(1'b0);
        dir_status.push_back('0);
    endtask

    task automatic add_known(mmapc_pkg::action_t a, int s, bit sv, bit lv,
                             int avg, bit ok, bit ht, bit pm, bit ao, bit ch);
        status_t e;
        add_row(a, s, sv, lv);
        e.avg      = avg[11:0];
        e.avg_ok   = ok;
        e.heat     = ht;
        e.pump     = pm;
        e.auto_off = ao;
        e.changed  = ch;
        void'(dir_known.pop_back());
        void'(dir_status.pop_back());
        dir_known.push_back(1'b1);
        dir_status.push_back(e);
    endtask

    function automatic cmd_t rand_cmd(int base);
        cmd_t c;
        int   pick;
        int   v;
        pick     = $urandom_range(99);
        c.sample = 12'($urandom);
        c.svalid = 1'($urandom);
        c.level  = 1'($urandom);
        if (pick < 65)
        begin
            c.act = mmapc_pkg::ACT_SAMPLE;
            // mostly near the segment's base temperature, some full range
            if ($urandom_range(9) != 0)
            begin
                v        = base + int'($urandom_range(160)) - 80;
                c.sample = v[11:0];
            end
            c.svalid = ($urandom_range(9) != 0);
        end
        else if (pick < 80)
        begin
            c.act   = mmapc_pkg::ACT_PUMP;
            c.level = ($urandom_range(4) != 0);
        end
        else if (pick < 92)
        begin
            c.act   = mmapc_pkg::ACT_HEAT;
            c.level = ($urandom_range(3) == 0);
        end
        else
            c.act = mmapc_pkg::ACT_NONE;
        return c;
    endfunction

    // status channel: check accepted beats, randomize ready
    initial
    begin
        status_t exp_st;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (pending_status.size() == 0)
                    flag_field("unexpected status beat", 1, 0);
                else
                begin
                    exp_st = pending_status.pop_front();
                    flag_field("average", int'($signed(out_ch.average)),
                               int'($signed(exp_st.avg)));
                    flag_field("average_valid", int'(out_ch.average_valid),
                               int'(exp_st.avg_ok));
                    flag_field("heat_on", int'(out_ch.heat_on), int'(exp_st.heat));
                    flag_field("pump_on", int'(out_ch.pump_on), int'(exp_st.pump));
                    flag_field("pump_auto_off", int'(out_ch.pump_auto_off),
                               int'(exp_st.auto_off));
                    flag_field("relay_changed", int'(out_ch.relay_changed),
                               int'(exp_st.changed));
                end
            end
            if (stall_req)
            begin
                stall_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    initial
    begin
        int   k;
        int   seg;
        int   i;
        int   base;
        int   burst_at;
        int   thr;
        cmd_t c;
        status_t model;

        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.action       <= mmapc_pkg::ACT_NONE;
        in_ch.sample       <= '0;
        in_ch.sample_valid <= 1'b0;
        in_ch.level        <= 1'b0;

        for (k = 0; k < mmapc_pkg::WINDOW; k++)
        begin
            ring_ok[k]  = 1'b0;
            ring_val[k] = 0;
        end
        wr_slot    = 0;
        run_sum    = 0;
        run_cnt    = 0;
        avg_hold   = 0;
        avg_seen   = 1'b0;
        heat_st    = 1'b0;
        pump_st    = 1'b0;
        cut_thresh = int'(mmapc_pkg::THRESH_RESET);
        mismatches = 0;
        cycle_count = 0;
        snd_idle   = 0;
        rcv_idle   = 0;
        stall_req  = 1'b0;
        hold_left  = 0;

        // reset threshold in force; relays off; no average yet
        add_known(mmapc_pkg::ACT_NONE,       0, 0, 0,     0, 0, 0, 0, 0, 0);
        add_known(mmapc_pkg::ACT_PUMP,       0, 0, 1,     0, 0, 0, 1, 0, 1);
        add_known(mmapc_pkg::ACT_SAMPLE,  2047, 0, 0,     0, 0, 0, 1, 0, 0);
        add_known(mmapc_pkg::ACT_PUMP,       0, 0, 1,     0, 0, 0, 1, 0, 0);
        add_known(mmapc_pkg::ACT_SAMPLE, -2048, 1, 0, -2048, 1, 0, 0, 1, 0);
        add_known(mmapc_pkg::ACT_PUMP,       0, 0, 1, -2048, 1, 0, 1, 0, 1);
        add_known(mmapc_pkg::ACT_HEAT,       0, 0, 1, -2048, 1, 1, 1, 0, 1);
        // -1 / 2 truncates to 0; heat on keeps the pump
        add_known(mmapc_pkg::ACT_SAMPLE,  2047, 1, 0,     0, 1, 1, 1, 0, 0);
        add_row(mmapc_pkg::ACT_SAMPLE, -2048, 1, 0);
        add_row(mmapc_pkg::ACT_HEAT,       0, 0, 0);
        add_row(mmapc_pkg::ACT_SAMPLE,  2047, 1, 0);
        add_row(mmapc_pkg::ACT_SAMPLE,    -5, 0, 0);
        add_row(mmapc_pkg::ACT_NONE,      -1, 1, 1);
        add_row(mmapc_pkg::ACT_PUMP,       0, 0, 0);
        add_row(mmapc_pkg::ACT_HEAT,       0, 0, 0);
        add_row(mmapc_pkg::ACT_PUMP,       0, 0, 1);
        add_row(mmapc_pkg::ACT_SAMPLE,  1000, 1, 0);
        add_row(mmapc_pkg::ACT_PUMP,       0, 0, 1);
        add_row(mmapc_pkg::ACT_SAMPLE,  2047, 1, 0);
        add_row(mmapc_pkg::ACT_SAMPLE,     0, 1, 0);
        // average lands exactly on the threshold, then one below it
        add_row(mmapc_pkg::ACT_SAMPLE,   283, 1, 0);
        add_row(mmapc_pkg::ACT_SAMPLE,   407, 1, 1);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < dir_cmd.size(); k++)
        begin
            drive_cmd(dir_cmd[k]);
            model = predict_status(dir_cmd[k]);
            pending_status.push_back(dir_known[k] ? dir_status[k] : model);
        end

        for (seg = 0; seg < 6; seg++)
        begin
            drain();
            base = int'($urandom_range(3000)) - 1500;
            unique case (seg)
                0: thr = 2047;
                1: thr = -2048;
                3: thr = int'($urandom_range(4095)) - 2048;
                default: thr = base + int'($urandom_range(60)) - 30;
            endcase
            write_thresh(thr);
            snd_idle = (seg < 2) ? 16 : (seg < 4) ? 79 : 0;
            rcv_idle = (seg < 2) ? 79 : (seg < 4) ? 16 : 0;
            if (seg == 4)
                stall_req = 1'b1;
            burst_at = (seg % 2 == 1) ? int'($urandom_range(100)) : -1;
            for (i = 0; i < SEG_ITEMS; i++)
            begin
                // a run of invalid samples longer than the window empties the ring
                if (i == burst_at)
                    repeat (mmapc_pkg::WINDOW + 2)
                    begin
                        c        = rand_cmd(base);
                        c.act    = mmapc_pkg::ACT_SAMPLE;
                        c.svalid = 1'b0;
                        issue(c);
                    end
                issue(rand_cmd(base));
            end
        end

        drain();
        if (mismatches == 0)
            $display("** masked_moving_average_pump_control_unit: PASSED **");
        else
            $display("** masked_moving_average_pump_control_unit: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/mmapc_pkg.sv
design/mmapc_if.sv
design/masked_moving_average_pump_control_unit.sv
tb/tb_masked_moving_average_pump_control_unit.sv
